// File: hdl/assert_macros.svh
// Assertion helper macros
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_IMPL(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// File: hdl/tscm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscm_pkg
// Shared types and constants of the true-stereo convolution mixer.
// ----------------------------------------------------------------------------
package tscm_pkg;
    localparam int TAPS = 1024;
    localparam int TW   = $clog2(TAPS);
    localparam int LW   = $clog2(TAPS + 1);

    typedef enum logic [1:0] {
        FN_SAMPLE = 2'd0,
        FN_WRITE  = 2'd1,
        FN_COMMIT = 2'd2,
        FN_CLEAR  = 2'd3
    } t_func;

    localparam logic [1:0] REG_PAN  = 2'd0;
    localparam logic [1:0] REG_WET  = 2'd1;
    localparam logic [1:0] REG_GAIN = 2'd2;
    localparam logic [1:0] REG_MODE = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_MAC,
        ST_DRAIN,
        ST_MIX,
        ST_OUT
    } t_state;

    // lane control from the sequencer
    typedef struct packed {
        logic          clr;
        logic          en;
        logic [TW-1:0] tap;
        logic [TW-1:0] hidx;
        logic          bank;
        logic          we_h;
        logic [TW-1:0] waddr;
        logic [23:0]   wdata;
    } t_lane_ctl;

    function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v,
                                                     input int s);
        logic signed [63:0] t;
        t = v + (64'sd1 <<< (s - 1));
        return t >>> s;
    endfunction
endpackage
`default_nettype wire

// File: hdl/tscm_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscm_lane
// One input channel: delay line memory, two coefficient memories per bank
// and two MAC units for the L and R paths.
// ----------------------------------------------------------------------------
module tscm_lane (
    input  wire logic                      i_clk,
    input  wire tscm_pkg::t_lane_ctl       i_ctl,
    input  wire logic                      i_cwe,
    input  wire logic                      i_cbank,
    input  wire logic                      i_cpath,
    input  wire logic [tscm_pkg::TW-1:0]   i_ctap,
    input  wire logic [23:0]               i_cval,
    output logic signed [63:0]             o_accl,
    output logic signed [63:0]             o_accr
);
    import tscm_pkg::*;

    logic [23:0] r_hist [TAPS];
    logic [23:0] r_cl [2*TAPS];
    logic [23:0] r_cr [2*TAPS];
    logic signed [23:0] r_h, r_kl, r_kr;
    logic signed [47:0] r_pl, r_pr;
    logic r_v0, r_v1;
    logic signed [63:0] r_accl, r_accr;

    always_ff @(posedge i_clk) begin
        if (i_ctl.we_h) r_hist[i_ctl.waddr] <= i_ctl.wdata;
        r_h <= r_hist[i_ctl.hidx];
    end

    always_ff @(posedge i_clk) begin
        if (i_cwe && !i_cpath) r_cl[{i_cbank, i_ctap}] <= i_cval;
        r_kl <= r_cl[{i_ctl.bank, i_ctl.tap}];
    end

    always_ff @(posedge i_clk) begin
        if (i_cwe && i_cpath) r_cr[{i_cbank, i_ctap}] <= i_cval;
        r_kr <= r_cr[{i_ctl.bank, i_ctl.tap}];
    end

    always_ff @(posedge i_clk) begin
        r_v0 <= i_ctl.en;
        r_v1 <= r_v0;
        r_pl <= r_h * r_kl;
        r_pr <= r_h * r_kr;
        if (i_ctl.clr) begin
            r_accl <= '0;
            r_accr <= '0;
        end else if (r_v1) begin
            r_accl <= r_accl + 64'(r_pl);
            r_accr <= r_accr + 64'(r_pr);
        end
    end

    assign o_accl = r_accl;
    assign o_accr = r_accr;
endmodule
`default_nettype wire

// File: hdl/tscm_mix.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tscm_mix
// Merge stage: combines lane sums with the dry path, applies gains, saturates.
// ----------------------------------------------------------------------------
module tscm_mix (
    input  wire logic               i_clk,
    input  wire logic [1:0]         i_step,
    input  wire logic signed [63:0] i_accl,
    input  wire logic signed [63:0] i_accr,
    input  wire logic signed [24:0] i_dry_l,
    input  wire logic signed [24:0] i_dry_r,
    input  wire logic signed [23:0] i_busl,
    input  wire logic signed [23:0] i_busr,
    input  wire logic signed [18:0] i_gain,
    input  wire logic [16:0]        i_wet,
    input  wire logic               i_use_dry,
    input  wire logic               i_use_wet,
    output logic signed [23:0]      o_left,
    output logic signed [23:0]      o_right
);
    import tscm_pkg::*;

    logic signed [19:0] r_dg, r_wg;
    logic signed [39:0] r_wl, r_wr;
    logic signed [63:0] r_sl, r_sr;
    logic signed [63:0] n_tl, n_tr;
    logic [16:0] w_dry;

    assign w_dry = 17'd32768 - i_wet;

    function automatic logic signed [23:0] sat(input logic signed [63:0] v);
        if (v > 64'sd8388607) return 24'sh7FFFFF;
        if (v < -64'sd8388608) return 24'sh800000;
        return v[23:0];
    endfunction

    always_comb begin
        n_tl = 64'(i_busl) + rnd_shift(r_sl, 16);
        n_tr = 64'(i_busr) + rnd_shift(r_sr, 16);
    end

    always_ff @(posedge i_clk) begin
        case (i_step)
            2'd0: begin
                r_dg <= 20'(rnd_shift(64'($signed({1'b0, w_dry})) * 64'(i_gain), 15));
                r_wg <= 20'(rnd_shift(64'($signed({1'b0, i_wet})) * 64'(i_gain), 15));
                r_wl <= 40'(rnd_shift(i_accl, 23));
                r_wr <= 40'(rnd_shift(i_accr, 23));
            end
            2'd1: begin
                r_sl <= (i_use_dry ? 64'(r_dg) * 64'(i_dry_l) : 64'sd0)
                      + (i_use_wet ? 64'(r_wg) * 64'(r_wl) * 64'sd2 : 64'sd0);
                r_sr <= (i_use_dry ? 64'(r_dg) * 64'(i_dry_r) : 64'sd0)
                      + (i_use_wet ? 64'(r_wg) * 64'(r_wr) * 64'sd2 : 64'sd0);
            end
            2'd2: begin
                o_left  <= sat(n_tl);
                o_right <= sat(n_tr);
            end
            default: begin
                r_sl <= r_sl;
            end
        endcase
    end
endmodule
`default_nettype wire

// File: hdl/true_stereo_convolution_mixer.sv
`timescale 1ns / 1ps
`default_nettype none
// Sample item: with wet paths a MAC pass over the bank length, a drain and the mix run;
// without wet paths only the mix runs; a muted item goes straight to the output. A
// coefficient write returns to idle. Commit (nonzero length) and clear run the delay line
// clearing pass; so does reset before the first item is accepted, while config writes are
// taken. One item is in flight at a time; the result sits in an output register.
// ----------------------------------------------------------------------------
// true_stereo_convolution_mixer
// Sequencer, two channel lanes and merge stage.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module true_stereo_convolution_mixer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // fields low to high: sample_a, sample_b, bus_left_in, bus_right_in,
    // path_select, tap_index, coefficient, response_length, pad
    input  wire logic [143:0] s_axis_tdata,
    // func
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // fields low to high: bus_left_out, bus_right_out, active_paths, pad
    output logic [55:0]      m_axis_tdata,
    input  wire logic        i_cfg_we,
    input  wire logic [1:0]  i_cfg_idx,
    input  wire logic [18:0] i_cfg_data
);
    import tscm_pkg::*;

    logic [15:0] r_pan;
    logic [15:0] r_wetr;
    logic [18:0] r_gain;
    logic [3:0]  r_mode;

    t_state r_st, n_st;
    logic [LW-1:0] r_cnt, n_cnt;
    logic [TW-1:0] r_pa, r_pb;
    logic r_bank;
    logic [1:0] r_loaded;
    logic [LW-1:0] r_len [2];
    logic r_ua, r_ub, r_ud;
    logic [2:0] r_paths;
    logic signed [23:0] r_busl, r_busr;
    logic signed [24:0] r_dl, r_dr;
    logic r_ov;
    logic [47:0] r_oval;
    logic [2:0] r_opaths;
    logic r_mute;

    logic acc;
    t_func w_fn;
    logic signed [23:0] w_a, w_b;
    logic [16:0] w_wet;
    logic signed [16:0] w_ga, w_gb, w_pan;
    logic w_wetok, w_ua, w_ub;
    logic [LW-1:0] w_clen;
    t_lane_ctl w_ca, w_cb;
    logic signed [63:0] al_a, ar_a, al_b, ar_b;
    logic signed [23:0] mo_l, mo_r;
    logic [1:0] w_step;
    logic [LW-1:0] w_alen;

    assign s_axis_tready = (r_st == ST_IDLE) && !r_ov;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign w_fn = t_func'(s_axis_tuser);
    assign w_pan = 17'(signed'(r_pan));
    assign w_wet = (r_wetr > 16'd32768) ? 17'd32768 : {1'b0, r_wetr};
    assign w_ga = (w_pan > 0) ? 17'sd32768 - w_pan : 17'sd32768;
    assign w_gb = (w_pan < 0) ? 17'sd32768 + w_pan : 17'sd32768;
    assign w_wetok = r_mode[1] && r_loaded[r_bank] && (w_wet != 0);
    assign w_ua = w_wetok && (w_ga != 0) && r_mode[2];
    assign w_ub = w_wetok && (w_gb != 0) && r_mode[3];
    assign w_a = r_mode[2] ? s_axis_tdata[23:0] : 24'sd0;
    assign w_b = r_mode[3] ? s_axis_tdata[47:24] : 24'sd0;
    assign w_clen = (s_axis_tdata[142:132] > 11'(TAPS)) ? LW'(TAPS)
                                                        : LW'(s_axis_tdata[142:132]);
    assign w_alen = r_len[r_bank];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pan <= '0; r_wetr <= '0; r_gain <= 19'd32768; r_mode <= 4'd14;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_PAN:  r_pan  <= i_cfg_data[15:0];
                REG_WET:  r_wetr <= i_cfg_data[15:0];
                REG_GAIN: r_gain <= i_cfg_data;
                REG_MODE: r_mode <= i_cfg_data[3:0];
                default:  r_mode <= r_mode;
            endcase
        end
    end

    always_comb begin
        n_st = r_st;
        n_cnt = r_cnt;
        case (r_st)
            ST_IDLE: begin
                n_cnt = '0;
                if (acc) begin
                    case (w_fn)
                        FN_SAMPLE: n_st = (signed'(r_gain) == 0) ? ST_OUT :
                                          ((w_ua || w_ub) ? ST_MAC : ST_MIX);
                        FN_COMMIT: n_st = (s_axis_tdata[142:132] != 0) ? ST_CLEAR
                                                                       : ST_IDLE;
                        FN_CLEAR:  n_st = ST_CLEAR;
                        default:   n_st = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LW'(TAPS - 1)) n_st = ST_IDLE;
            end
            ST_MAC: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == w_alen - 1'b1) begin n_st = ST_DRAIN; n_cnt = '0; end
            end
            ST_DRAIN: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LW'(3)) begin n_st = ST_MIX; n_cnt = '0; end
            end
            ST_MIX: begin
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == LW'(2)) n_st = ST_OUT;
            end
            ST_OUT:  n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ca = '0;
        w_cb = '0;
        w_ca.bank = r_bank; w_cb.bank = r_bank;
        w_ca.tap = r_cnt[TW-1:0]; w_cb.tap = r_cnt[TW-1:0];
        w_ca.hidx = r_pa - TW'(1) - r_cnt[TW-1:0];
        w_cb.hidx = r_pb - TW'(1) - r_cnt[TW-1:0];
        w_ca.en = (r_st == ST_MAC) && r_ua;
        w_cb.en = (r_st == ST_MAC) && r_ub;
        w_step = (r_st == ST_MIX) ? r_cnt[1:0] : 2'd3;
        case (r_st)
            ST_IDLE: begin
                w_ca.clr = 1'b1; w_cb.clr = 1'b1;
                w_ca.we_h = acc && (w_fn == FN_SAMPLE) && w_ua;
                w_cb.we_h = acc && (w_fn == FN_SAMPLE) && w_ub;
                w_ca.waddr = r_pa; w_cb.waddr = r_pb;
                w_ca.wdata = 24'(rnd_shift(64'(w_a) * 64'(w_ga), 15));
                w_cb.wdata = 24'(rnd_shift(64'(w_b) * 64'(w_gb), 15));
            end
            ST_CLEAR: begin
                w_ca.we_h = 1'b1; w_cb.we_h = 1'b1;
                w_ca.waddr = r_cnt[TW-1:0]; w_cb.waddr = r_cnt[TW-1:0];
            end
            default: w_ca.clr = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR; r_cnt <= '0; r_pa <= '0; r_pb <= '0;
            r_bank <= 1'b0; r_loaded <= '0; r_len[0] <= '0; r_len[1] <= '0;
            r_ov <= 1'b0; r_ua <= 1'b0; r_ub <= 1'b0; r_ud <= 1'b0;
            r_paths <= '0; r_mute <= 1'b0;
        end else begin
            r_st <= n_st;
            r_cnt <= n_cnt;
            if (m_axis_tvalid && m_axis_tready) r_ov <= 1'b0;
            if (r_st == ST_OUT) begin
                r_ov <= 1'b1;
                r_oval <= r_mute ? {r_busr, r_busl} : {mo_r, mo_l};
                r_opaths <= r_mute ? 3'd0 : r_paths;
            end
            if (acc) begin
                case (w_fn)
                    FN_SAMPLE: begin
                        r_mute <= (signed'(r_gain) == 0);
                        r_ua <= w_ua; r_ub <= w_ub;
                        r_ud <= (w_wet != 17'd32768);
                        r_paths <= 3'((w_ua ? 2 : 0) + (w_ub ? 2 : 0));
                        if (w_ua && signed'(r_gain) != 0) r_pa <= r_pa + 1'b1;
                        if (w_ub && signed'(r_gain) != 0) r_pb <= r_pb + 1'b1;
                    end
                    FN_COMMIT: if (s_axis_tdata[142:132] != 0) begin
                        r_len[!r_bank] <= w_clen;
                        r_loaded[!r_bank] <= 1'b1;
                        r_bank <= !r_bank;
                        r_pa <= '0; r_pb <= '0;
                    end
                    FN_CLEAR: begin
                        r_loaded[!r_bank] <= 1'b0;
                        r_bank <= !r_bank;
                        r_pa <= '0; r_pb <= '0;
                    end
                    default: r_bank <= r_bank;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_busl <= s_axis_tdata[71:48];
            r_busr <= s_axis_tdata[95:72];
            if (r_mode[0]) begin
                r_dl <= 25'(w_a) + 25'(w_b);
                r_dr <= 25'(w_a) + 25'(w_b);
            end else begin
                r_dl <= 25'(w_a) <<< 1;
                r_dr <= 25'(w_b) <<< 1;
            end
        end
    end

    tscm_lane u_lane_a (
        .i_clk(i_clk), .i_ctl(w_ca),
        .i_cwe(acc && w_fn == FN_WRITE && !s_axis_tdata[97]),
        .i_cbank(!r_bank), .i_cpath(s_axis_tdata[96]),
        .i_ctap(s_axis_tdata[107:98]), .i_cval(s_axis_tdata[131:108]),
        .o_accl(al_a), .o_accr(ar_a)
    );

    tscm_lane u_lane_b (
        .i_clk(i_clk), .i_ctl(w_cb),
        .i_cwe(acc && w_fn == FN_WRITE && s_axis_tdata[97]),
        .i_cbank(!r_bank), .i_cpath(s_axis_tdata[96]),
        .i_ctap(s_axis_tdata[107:98]), .i_cval(s_axis_tdata[131:108]),
        .o_accl(al_b), .o_accr(ar_b)
    );

    tscm_mix u_mix (
        .i_clk(i_clk), .i_step(w_step),
        .i_accl(al_a + al_b), .i_accr(ar_a + ar_b),
        .i_dry_l(r_dl), .i_dry_r(r_dr), .i_busl(r_busl), .i_busr(r_busr),
        .i_gain(r_gain), .i_wet(w_wet), .i_use_dry(r_ud),
        .i_use_wet(r_ua || r_ub), .o_left(mo_l), .o_right(mo_r)
    );

    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata = {5'd0, r_opaths, r_oval};

    `ASSERT_IMPL(a_busy_noready, i_clk, i_rst_n, (r_st != ST_IDLE) |-> !s_axis_tready)
    `ASSERT_NEVER(a_paths_odd, i_clk, i_rst_n, m_axis_tvalid && m_axis_tdata[48])
    `ASSERT_IMPL(a_out_after, i_clk, i_rst_n, (r_st == ST_OUT) |=> m_axis_tvalid)
endmodule
`default_nettype wire

// File: verif/true_stereo_convolution_mixer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// true_stereo_convolution_mixer_tb
// Drives sample, coefficient, commit and clear transactions with random gaps
// and output back-pressure. A scoreboard class predicts every sample result
// from its own copy of the delay lines, banks and registers and compares the
// results in order. Register settings change between phases while idle.
// ----------------------------------------------------------------------------
module true_stereo_convolution_mixer_tb;
    import tscm_pkg::*;

    localparam int  SETTLE_CYCLES = 1100;
    localparam int  TARGET_ITEMS  = 540;
    localparam longint CYCLE_LIMIT = 3000000;

    typedef struct {
        t_func       fn;
        logic [23:0] smp_a;
        logic [23:0] smp_b;
        logic [23:0] bus_l;
        logic [23:0] bus_r;
        logic [1:0]  path;
        logic [9:0]  tap;
        logic [23:0] coef;
        logic [10:0] len;
    } t_mix_item;

    typedef struct packed {
        logic [2:0]  paths;
        logic [23:0] bus_r;
        logic [23:0] bus_l;
    } t_mix_out;

    class mixer_scoreboard;
        longint   coef_mem[8*TAPS];
        bit       coef_set[8*TAPS];
        longint   hist_mem[2*TAPS];
        int       hptr[2];
        int       act_bank;
        bit [1:0] loaded;
        int       blen[2];
        logic [15:0] pan_r;
        logic [15:0] wet_r;
        logic [18:0] gain_r;
        logic [3:0]  mode_r;
        t_mix_out expected_q[$];
        int errors;
        int mismatches;

        function new();
            foreach (coef_mem[i]) begin
                coef_mem[i] = 0;
                coef_set[i] = 0;
            end
            clear_lines();
            act_bank = 0;
            loaded = 0;
            blen[0] = 0;
            blen[1] = 0;
            pan_r = 0;
            wet_r = 0;
            gain_r = 19'd32768;
            mode_r = 4'd14;
            errors = 0;
            mismatches = 0;
        endfunction

        function void clear_lines();
            foreach (hist_mem[i]) hist_mem[i] = 0;
            hptr[0] = 0;
            hptr[1] = 0;
        endfunction

        function longint round_shift(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function longint sat24(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function int pending_bank();
            return act_bank ^ 1;
        endfunction

        function void write_reg(logic [1:0] idx, logic [18:0] v);
            case (idx)
                REG_PAN:  pan_r = v[15:0];
                REG_WET:  wet_r = v[15:0];
                REG_GAIN: gain_r = v;
                REG_MODE: mode_r = v[3:0];
                default: ;
            endcase
        endfunction

        function void run_line(int ch, longint x, ref longint accl, ref longint accr);
            int p;
            int base;
            longint sl;
            longint sr;
            longint h;
            p = hptr[ch];
            base = (act_bank * 4 + ch * 2) * TAPS;
            sl = 0;
            sr = 0;
            hist_mem[ch * TAPS + p] = x;
            for (int k = 0; k < blen[act_bank]; k++) begin
                h = hist_mem[ch * TAPS + (p + TAPS - k) % TAPS];
                sl += coef_mem[base + k] * h;
                sr += coef_mem[base + TAPS + k] * h;
            end
            accl += sl;
            accr += sr;
            hptr[ch] = (p + 1) % TAPS;
        endfunction

        function void note_input(t_mix_item it);
            int pend;
            int idx;
            int ln;
            longint a, b, bl, br, pan, gain, wet, dry, ga, gb, dg, wg;
            longint accl, accr, suml, sumr;
            bit has_a, has_b, wet_ok, use_a, use_b;
            t_mix_out res;
            int paths;
            pend = pending_bank();
            case (it.fn)
                FN_WRITE: begin
                    idx = (pend * 4 + it.path) * TAPS + it.tap;
                    coef_mem[idx] = longint'($signed(it.coef));
                    coef_set[idx] = 1;
                end
                FN_COMMIT: begin
                    ln = it.len;
                    if (ln != 0) begin
                        if (ln > TAPS) ln = TAPS;
                        blen[pend] = ln;
                        loaded[pend] = 1;
                        act_bank = pend;
                        clear_lines();
                    end
                end
                FN_CLEAR: begin
                    loaded[pend] = 0;
                    act_bank = pend;
                    clear_lines();
                end
                default: begin
                    a = longint'($signed(it.smp_a));
                    b = longint'($signed(it.smp_b));
                    bl = longint'($signed(it.bus_l));
                    br = longint'($signed(it.bus_r));
                    pan = longint'($signed(pan_r));
                    gain = longint'($signed(gain_r));
                    wet = (wet_r > 16'd32768) ? 32768 : longint'(wet_r);
                    dry = 32768 - wet;
                    ga = (pan > 0) ? 32768 - pan : 32768;
                    gb = (pan < 0) ? 32768 + pan : 32768;
                    has_a = mode_r[2];
                    has_b = mode_r[3];
                    wet_ok = mode_r[1] && loaded[act_bank] && wet > 0;
                    use_a = wet_ok && ga > 0 && has_a;
                    use_b = wet_ok && gb > 0 && has_b;
                    accl = 0;
                    accr = 0;
                    suml = 0;
                    sumr = 0;
                    paths = 0;
                    if (!has_a) a = 0;
                    if (!has_b) b = 0;
                    if (gain != 0) begin
                        if (use_a) begin
                            run_line(0, round_shift(a * ga, 15), accl, accr);
                            paths += 2;
                        end
                        if (use_b) begin
                            run_line(1, round_shift(b * gb, 15), accl, accr);
                            paths += 2;
                        end
                        if (dry > 0) begin
                            dg = round_shift(dry * gain, 15);
                            if (mode_r[0]) begin
                                suml += dg * (a + b);
                                sumr += dg * (a + b);
                            end else begin
                                suml += dg * a * 2;
                                sumr += dg * b * 2;
                            end
                        end
                        if (use_a || use_b) begin
                            wg = round_shift(wet * gain, 15);
                            suml += wg * round_shift(accl, 23) * 2;
                            sumr += wg * round_shift(accr, 23) * 2;
                        end
                        bl = sat24(bl + round_shift(suml, 16));
                        br = sat24(br + round_shift(sumr, 16));
                    end
                    res.bus_l = bl[23:0];
                    res.bus_r = br[23:0];
                    res.paths = paths[2:0];
                    expected_q.push_back(res);
                end
            endcase
        endfunction

        function void check_result(logic [55:0] d);
            t_mix_out exp_r;
            t_mix_out act_r;
            act_r = d[50:0];
            if (expected_q.size() == 0) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result l=%0d r=%0d paths=%0d",
                             $signed(act_r.bus_l), $signed(act_r.bus_r), act_r.paths);
                return;
            end
            exp_r = expected_q.pop_front();
            if (act_r !== exp_r) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: exp l=%0d r=%0d paths=%0d, got l=%0d r=%0d paths=%0d",
                             $signed(exp_r.bus_l), $signed(exp_r.bus_r), exp_r.paths,
                             $signed(act_r.bus_l), $signed(act_r.bus_r), act_r.paths);
            end
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [143:0] s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [55:0]  m_axis_tdata;
    logic         i_cfg_we;
    logic [1:0]   i_cfg_idx;
    logic [18:0]  i_cfg_data;

    mixer_scoreboard sb;
    longint cycles;
    bit     no_gaps;
    bit     no_stalls;
    int     stall_hold;
    int     item_count;

    true_stereo_convolution_mixer u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 15);
        return $urandom_range(16, 200);
    endfunction

    function automatic logic [23:0] rand_q23();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return 24'h000000;
            3: return 24'hFFFFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic t_mix_item rand_item(t_func fn);
        t_mix_item it;
        it.fn = fn;
        it.smp_a = rand_q23();
        it.smp_b = rand_q23();
        it.bus_l = rand_q23();
        it.bus_r = rand_q23();
        it.path = 2'($urandom_range(0, 3));
        it.tap = 10'($urandom_range(0, TAPS - 1));
        it.coef = rand_q23();
        it.len = 11'($urandom_range(0, 2047));
        return it;
    endfunction

    // back-pressure on the result side
    always @(negedge i_clk) begin
        if (no_stalls) begin
            m_axis_tready = 1'b1;
        end else if (stall_hold > 0) begin
            stall_hold--;
        end else begin
            m_axis_tready = $urandom_range(0, 2) != 0;
            stall_hold = gap_len();
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic push_item(t_mix_item it);
        int g;
        g = no_gaps ? 0 : gap_len();
        @(negedge i_clk);
        if (g > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (g) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tuser = it.fn;
        s_axis_tdata = {1'b0, it.len, it.coef, it.tap, it.path,
                        it.bus_r, it.bus_l, it.smp_b, it.smp_a};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_input(it);
    endtask

    task automatic settle();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_regs(logic [15:0] pan, logic [15:0] wet, logic [18:0] gain,
                                logic [3:0] mode);
        logic [18:0] vals[4];
        vals[0] = {{3{pan[15]}}, pan};
        vals[1] = {3'b0, wet};
        vals[2] = gain;
        vals[3] = {15'b0, mode};
        settle();
        for (int i = 0; i < 4; i++) begin
            @(negedge i_clk);
            i_cfg_we = 1'b1;
            i_cfg_idx = i[1:0];
            i_cfg_data = vals[i];
            sb.write_reg(i[1:0], vals[i]);
        end
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // fill every tap the commit will read, then commit
    task automatic load_bank(logic [10:0] len);
        t_mix_item it;
        int eff;
        int pend;
        eff = (len > TAPS) ? TAPS : int'(len);
        pend = sb.pending_bank();
        for (int p = 0; p < 4; p++) begin
            for (int t = 0; t < eff; t++) begin
                if (!sb.coef_set[(pend * 4 + p) * TAPS + t]) begin
                    it = rand_item(FN_WRITE);
                    it.path = 2'(p);
                    it.tap = 10'(t);
                    if ($urandom_range(0, 3) == 0)
                        it.coef = 24'($urandom_range(0, 4095) - 2048);
                    push_item(it);
                    item_count++;
                end
            end
        end
        it = rand_item(FN_COMMIT);
        it.len = len;
        push_item(it);
        item_count++;
    endtask

    task automatic random_op(bit allow_load);
        t_mix_item it;
        int r;
        r = $urandom_range(0, 99);
        if (r < 72 || !allow_load) begin
            push_item(rand_item(FN_SAMPLE));
            item_count++;
        end else if (r < 86) begin
            it = rand_item(FN_WRITE);
            if ($urandom_range(0, 1)) it.tap = 10'($urandom_range(0, 31));
            push_item(it);
            item_count++;
        end else if (r < 94) begin
            load_bank(11'($urandom_range(1, 24)));
        end else if (r < 97) begin
            it = rand_item(FN_COMMIT);
            it.len = 0;
            push_item(it);
            item_count++;
        end else begin
            push_item(rand_item(FN_CLEAR));
            item_count++;
        end
    endtask

    initial begin
        t_mix_item it;
        int phase;
        logic [15:0] pan;
        logic [15:0] wet;
        logic [18:0] gain;
        sb = new();
        cycles = 0;
        no_gaps = 0;
        no_stalls = 0;
        stall_hold = 0;
        item_count = 0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = FN_SAMPLE;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = REG_PAN;
        i_cfg_data = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset settings, no bank loaded: dry path only
        for (int i = 0; i < 4; i++) begin
            it = rand_item(FN_SAMPLE);
            it.smp_a = i[0] ? 24'h7FFFFF : 24'h800000;
            it.smp_b = i[1] ? 24'h7FFFFF : 24'h800000;
            it.bus_l = it.smp_a;
            it.bus_r = it.smp_b;
            push_item(it);
            item_count++;
        end

        phase = 0;
        while (item_count < TARGET_ITEMS) begin
            case (phase)
                0: program_regs(16'd0, 16'd16384, 19'd32768, 4'd14);
                1: program_regs(16'h8000, 16'd32768, 19'h3FFFF, 4'd15);
                2: program_regs(16'h7FFF, 16'hFFFF, 19'h40000, 4'd14);
                3: program_regs(16'd0, 16'd0, 19'd0, 4'd0);
                4: program_regs(16'd100, 16'd1, 19'h7FFFF, 4'd11);
                5: program_regs(16'hFF00, 16'd32767, 19'd1, 4'd7);
                default: begin
                    pan = 16'($urandom());
                    wet = ($urandom_range(0, 4) == 0) ? 16'($urandom())
                                                      : 16'($urandom_range(0, 32768));
                    case ($urandom_range(0, 5))
                        0: gain = 19'h3FFFF;
                        1: gain = 19'h40000;
                        2: gain = 19'd0;
                        default: gain = 19'($urandom());
                    endcase
                    program_regs(pan, wet, gain, 4'($urandom_range(0, 15)));
                end
            endcase
            no_gaps = (phase % 4) == 3;
            no_stalls = (phase % 5) == 4;

            if (phase == 2) begin
                load_bank(11'd24);
                for (int i = 0; i < 6; i++) begin
                    push_item(rand_item(FN_SAMPLE));
                    item_count++;
                end
                push_item(rand_item(FN_CLEAR));
                item_count++;
                push_item(rand_item(FN_CLEAR));
                item_count++;
            end
            if (phase == 0) begin
                load_bank(11'd3);
                for (int i = 0; i < 8; i++) begin
                    it = rand_item(FN_SAMPLE);
                    it.smp_a = i[0] ? 24'h7FFFFF : 24'h800000;
                    it.smp_b = i[1] ? 24'h7FFFFF : 24'h800000;
                    it.bus_l = i[2] ? 24'h7FFFFF : 24'h800000;
                    it.bus_r = i[2] ? 24'h800000 : 24'h7FFFFF;
                    push_item(it);
                    item_count++;
                end
            end else if ($urandom_range(0, 1)) begin
                load_bank(11'($urandom_range(1, 24)));
            end
            for (int i = 0; i < 40 && item_count < TARGET_ITEMS; i++)
                random_op(1);
            phase++;
        end

        settle();
        if (sb.errors == 0 && sb.expected_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule

// File: files.f
+incdir+hdl
hdl/tscm_pkg.sv
hdl/tscm_lane.sv
hdl/tscm_mix.sv
hdl/true_stereo_convolution_mixer.sv
verif/true_stereo_convolution_mixer_tb.sv
